### rtl/core/dual_axis_pid_servo_unit_macros.svh
// Assertion macros for the dual axis PID servo unit.
`ifndef DUAL_AXIS_PID_SERVO_UNIT_MACROS_SVH
`define DUAL_AXIS_PID_SERVO_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DPSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpsv: same-cycle check failed");
`define DPSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpsv: next-cycle check failed");
`else
`define DPSV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DPSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/dpsv_pkg.sv
// Types, constants and microcode program of the dual axis PID servo unit.
`default_nettype none

package dpsv_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int ERR_W       = SAMPLE_W + 1;
    localparam int DIFF_W      = SAMPLE_W + 2;
    localparam int SUM_W       = 18;
    localparam int GAIN_W      = 20;
    localparam int LEVEL_W     = 16;
    localparam int SCALE_W     = 17;
    localparam int MUL_W       = 21;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 58;
    localparam int SPLIT_W     = 20;
    localparam int TAU_HI_W    = 20;
    localparam int GAIN_FRAC   = 16;
    localparam int SCALE_FRAC  = 16;
    localparam int DRIVE_SHIFT = GAIN_FRAC + SCALE_FRAC;
    localparam int Q_W         = ACC_W - DRIVE_SHIFT;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int PC_W        = 5;

    localparam logic [SCALE_W-1:0] SCALE_X  = 17'd56689;
    localparam logic [SCALE_W-1:0] SCALE_Y  = 17'd67043;
    localparam logic [SUM_W-1:0]   SUM_LOW  = 18'd37500;
    localparam logic [SUM_W-1:0]   SUM_HIGH = 18'd150000;

    localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 12'd2047;
    localparam logic [GAIN_W-1:0]   PROP_RST     = 20'd12003;
    localparam logic [GAIN_W-1:0]   DERIV_RST    = 20'd229376;
    localparam logic [GAIN_W-1:0]   INTEG_RST    = 20'd131;
    localparam logic [LEVEL_W-1:0]  NEUTRAL_RST  = 16'd1875;
    localparam logic [LEVEL_W-1:0]  CEILING_RST  = 16'd2375;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT_X,
        REG_SETPOINT_Y,
        REG_PROP_GAIN,
        REG_DERIV_GAIN,
        REG_INTEG_GAIN,
        REG_NEUTRAL_LEVEL,
        REG_OUTPUT_CEILING
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_x;
        logic [LEVEL_W-1:0] drive_y;
        logic               touch_present;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] setpoint_x;
        logic [SAMPLE_W-1:0] setpoint_y;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [LEVEL_W-1:0]  neutral_level;
        logic [LEVEL_W-1:0]  output_ceiling;
    } cfg_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_WAIT_IN,
        BR_WAIT_OUT,
        BR_JUMP
    } br_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_P,
        MUL_D,
        MUL_I,
        MUL_SLO,
        MUL_SHI
    } mul_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } acc_t;

    typedef enum logic [1:0] {
        DP_NOP,
        DP_LOAD_ERR,
        DP_DRIVE,
        DP_NEUTRAL
    } dpop_t;

    typedef enum logic {
        AXIS_X,
        AXIS_Y
    } axis_t;

    typedef struct packed {
        br_t             br;
        logic [PC_W-1:0] target;
        mul_t            mul;
        acc_t            acc;
        dpop_t           op;
        axis_t           axis;
    } ucode_t;

    typedef struct packed {
        mul_t  mul;
        acc_t  acc;
        dpop_t op;
        axis_t axis;
        logic  in_load;
        logic  out_load;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_WAIT    = 5'd0;
    localparam logic [PC_W-1:0] PC_EMIT    = 5'd19;
    localparam logic [PC_W-1:0] PC_NEUTRAL = 5'd20;

    function automatic logic touched(input in_t d);
        return (d.x_sample != '0) && (d.y_sample != '1);
    endfunction

    function automatic ucode_t uw(input br_t br, input logic [PC_W-1:0] target,
                                  input mul_t mul, input acc_t acc,
                                  input dpop_t op, input axis_t axis);
        ucode_t w;
        w.br     = br;
        w.target = target;
        w.mul    = mul;
        w.acc    = acc;
        w.op     = op;
        w.axis   = axis;
        return w;
    endfunction

    // Each axis: errors, three gain products summed into tau, then tau times
    // the axis scale in two halves, then the floored and saturated drive.
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            5'd0:  w = uw(BR_WAIT_IN, PC_NEUTRAL, MUL_NONE, ACC_HOLD, DP_NOP, AXIS_X);
            5'd1:  w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_HOLD, DP_LOAD_ERR, AXIS_X);
            5'd2:  w = uw(BR_NEXT, PC_WAIT, MUL_P, ACC_HOLD, DP_NOP, AXIS_X);
            5'd3:  w = uw(BR_NEXT, PC_WAIT, MUL_D, ACC_LOAD, DP_NOP, AXIS_X);
            5'd4:  w = uw(BR_NEXT, PC_WAIT, MUL_I, ACC_ADD, DP_NOP, AXIS_X);
            5'd5:  w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_ADD, DP_NOP, AXIS_X);
            5'd6:  w = uw(BR_NEXT, PC_WAIT, MUL_SLO, ACC_HOLD, DP_NOP, AXIS_X);
            5'd7:  w = uw(BR_NEXT, PC_WAIT, MUL_SHI, ACC_LOAD, DP_NOP, AXIS_X);
            5'd8:  w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_ADD_HI, DP_NOP, AXIS_X);
            5'd9:  w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_HOLD, DP_DRIVE, AXIS_X);
            5'd10: w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_HOLD, DP_LOAD_ERR, AXIS_Y);
            5'd11: w = uw(BR_NEXT, PC_WAIT, MUL_P, ACC_HOLD, DP_NOP, AXIS_Y);
            5'd12: w = uw(BR_NEXT, PC_WAIT, MUL_D, ACC_LOAD, DP_NOP, AXIS_Y);
            5'd13: w = uw(BR_NEXT, PC_WAIT, MUL_I, ACC_ADD, DP_NOP, AXIS_Y);
            5'd14: w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_ADD, DP_NOP, AXIS_Y);
            5'd15: w = uw(BR_NEXT, PC_WAIT, MUL_SLO, ACC_HOLD, DP_NOP, AXIS_Y);
            5'd16: w = uw(BR_NEXT, PC_WAIT, MUL_SHI, ACC_LOAD, DP_NOP, AXIS_Y);
            5'd17: w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_ADD_HI, DP_NOP, AXIS_Y);
            5'd18: w = uw(BR_NEXT, PC_WAIT, MUL_NONE, ACC_HOLD, DP_DRIVE, AXIS_Y);
            5'd19: w = uw(BR_WAIT_OUT, PC_WAIT, MUL_NONE, ACC_HOLD, DP_NOP, AXIS_X);
            5'd20: w = uw(BR_JUMP, PC_EMIT, MUL_NONE, ACC_HOLD, DP_NEUTRAL, AXIS_X);
            default: w = uw(BR_JUMP, PC_WAIT, MUL_NONE, ACC_HOLD, DP_NOP, AXIS_X);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dpsv_cfg.sv
// Configuration register file of the servo unit.
`default_nettype none

module dpsv_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dpsv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dpsv_pkg::CFG_W-1:0]     cfg_data,
    output dpsv_pkg::cfg_t                      cfg
);

    dpsv_pkg::cfg_t cfg_reg;
    dpsv_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dpsv_pkg::REG_SETPOINT_X:
                    cfg_next.setpoint_x = cfg_data[dpsv_pkg::SAMPLE_W-1:0];
                dpsv_pkg::REG_SETPOINT_Y:
                    cfg_next.setpoint_y = cfg_data[dpsv_pkg::SAMPLE_W-1:0];
                dpsv_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[dpsv_pkg::GAIN_W-1:0];
                dpsv_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = cfg_data[dpsv_pkg::GAIN_W-1:0];
                dpsv_pkg::REG_INTEG_GAIN:
                    cfg_next.integ_gain = cfg_data[dpsv_pkg::GAIN_W-1:0];
                dpsv_pkg::REG_NEUTRAL_LEVEL:
                    cfg_next.neutral_level = cfg_data[dpsv_pkg::LEVEL_W-1:0];
                dpsv_pkg::REG_OUTPUT_CEILING:
                    cfg_next.output_ceiling = cfg_data[dpsv_pkg::LEVEL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint_x     <= dpsv_pkg::SETPOINT_RST;
            cfg_reg.setpoint_y     <= dpsv_pkg::SETPOINT_RST;
            cfg_reg.prop_gain      <= dpsv_pkg::PROP_RST;
            cfg_reg.deriv_gain     <= dpsv_pkg::DERIV_RST;
            cfg_reg.integ_gain     <= dpsv_pkg::INTEG_RST;
            cfg_reg.neutral_level  <= dpsv_pkg::NEUTRAL_RST;
            cfg_reg.output_ceiling <= dpsv_pkg::CEILING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/dpsv_seq.sv
// Microcode sequencer: step counter, program ROM and branch logic.
`default_nettype none

module dpsv_seq (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_touch,
    input  wire logic      out_busy,
    output logic           in_stall,
    output dpsv_pkg::ctrl_t ctrl
);

    logic [dpsv_pkg::PC_W-1:0] pc_reg;
    logic [dpsv_pkg::PC_W-1:0] pc_next;
    logic [dpsv_pkg::PC_W-1:0] pc_inc;
    dpsv_pkg::ucode_t          word;
    logic                      in_load;
    logic                      out_load;

    assign word   = dpsv_pkg::ucode_word(pc_reg);
    assign pc_inc = pc_reg + dpsv_pkg::PC_W'(1);

    always_comb
    begin
        pc_next  = pc_reg;
        in_load  = 1'b0;
        out_load = 1'b0;
        unique case (word.br)
            dpsv_pkg::BR_NEXT:
                pc_next = pc_inc;
            dpsv_pkg::BR_WAIT_IN:
            begin
                in_load = in_valid;
                if (in_valid)
                begin
                    // An untouched panel skips the PID steps.
                    pc_next = in_touch ? pc_inc : word.target;
                end
            end
            dpsv_pkg::BR_WAIT_OUT:
            begin
                out_load = !out_busy;
                if (!out_busy)
                begin
                    pc_next = word.target;
                end
            end
            dpsv_pkg::BR_JUMP:
                pc_next = word.target;
            default:
                pc_next = dpsv_pkg::PC_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= dpsv_pkg::PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign in_stall      = (word.br != dpsv_pkg::BR_WAIT_IN);
    assign ctrl.mul      = word.mul;
    assign ctrl.acc      = word.acc;
    assign ctrl.op       = word.op;
    assign ctrl.axis     = word.axis;
    assign ctrl.in_load  = in_load;
    assign ctrl.out_load = out_load;

endmodule

`default_nettype wire

### rtl/core/dpsv_dp.sv
// PID datapath: error terms, one shared multiplier, accumulator and drive logic.
`default_nettype none

module dpsv_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  dpsv_pkg::ctrl_t      ctrl,
    input  dpsv_pkg::in_t        in_data,
    input  dpsv_pkg::cfg_t       cfg,
    output dpsv_pkg::out_t       out_data
);

    localparam int SAMPLE_W = dpsv_pkg::SAMPLE_W;
    localparam int ERR_W    = dpsv_pkg::ERR_W;
    localparam int DIFF_W   = dpsv_pkg::DIFF_W;
    localparam int SUM_W    = dpsv_pkg::SUM_W;
    localparam int GAIN_W   = dpsv_pkg::GAIN_W;
    localparam int LEVEL_W  = dpsv_pkg::LEVEL_W;
    localparam int SCALE_W  = dpsv_pkg::SCALE_W;
    localparam int MUL_W    = dpsv_pkg::MUL_W;
    localparam int PROD_W   = dpsv_pkg::PROD_W;
    localparam int ACC_W    = dpsv_pkg::ACC_W;
    localparam int SPLIT_W  = dpsv_pkg::SPLIT_W;
    localparam int HI_W     = dpsv_pkg::TAU_HI_W;
    localparam int SHIFT    = dpsv_pkg::DRIVE_SHIFT;
    localparam int Q_W      = dpsv_pkg::Q_W;

    logic [SAMPLE_W-1:0] x_smp_reg;
    logic [SAMPLE_W-1:0] y_smp_reg;
    logic                touch_reg;
    logic [ERR_W-1:0]    err_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic [SUM_W-1:0]    isum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [LEVEL_W-1:0]  drive_x_reg;
    logic [LEVEL_W-1:0]  drive_y_reg;
    dpsv_pkg::out_t      out_reg;

    logic [ERR_W-1:0]    last_x_reg;
    logic [ERR_W-1:0]    last_y_reg;
    logic [SUM_W-1:0]    sum_x_reg;
    logic [SUM_W-1:0]    sum_y_reg;

    logic [SAMPLE_W-1:0] sel_sp;
    logic [SAMPLE_W-1:0] sel_smp;
    logic [ERR_W-1:0]    sel_last;
    logic [SUM_W-1:0]    sel_sum;
    logic [SCALE_W-1:0]  sel_scale;
    logic [ERR_W-1:0]    err_c;
    logic [DIFF_W-1:0]   diff_c;
    logic signed [SUM_W:0] sum_raw;
    logic [SUM_W-1:0]    sum_c;

    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [ACC_W-1:0] prod_ext;

    logic [Q_W-1:0]      q_c;
    logic signed [Q_W:0] drive_sum;
    logic [LEVEL_W-1:0]  drive_c;

    // Error terms for the axis that the control word selects.
    always_comb
    begin
        if (ctrl.axis == dpsv_pkg::AXIS_X)
        begin
            sel_sp    = cfg.setpoint_x;
            sel_smp   = x_smp_reg;
            sel_last  = last_x_reg;
            sel_sum   = sum_x_reg;
            sel_scale = dpsv_pkg::SCALE_X;
        end
        else
        begin
            sel_sp    = cfg.setpoint_y;
            sel_smp   = y_smp_reg;
            sel_last  = last_y_reg;
            sel_sum   = sum_y_reg;
            sel_scale = dpsv_pkg::SCALE_Y;
        end
    end

    assign err_c   = {1'b0, sel_sp} - {1'b0, sel_smp};
    assign diff_c  = {err_c[ERR_W-1], err_c} - {sel_last[ERR_W-1], sel_last};
    assign sum_raw = $signed({1'b0, sel_sum})
                   + $signed({{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c});

    always_comb
    begin
        if (sum_raw < $signed({1'b0, dpsv_pkg::SUM_LOW}))
        begin
            sum_c = dpsv_pkg::SUM_LOW;
        end
        else if (sum_raw > $signed({1'b0, dpsv_pkg::SUM_HIGH}))
        begin
            sum_c = dpsv_pkg::SUM_HIGH;
        end
        else
        begin
            sum_c = sum_raw[SUM_W-1:0];
        end
    end

    // Operand selection for the shared multiplier. Tau is multiplied by the
    // axis scale in an unsigned low half and a signed high half.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul)
            dpsv_pkg::MUL_P:
            begin
                mul_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.prop_gain};
                mul_b = {{(MUL_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            dpsv_pkg::MUL_D:
            begin
                mul_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.deriv_gain};
                mul_b = {{(MUL_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
            end
            dpsv_pkg::MUL_I:
            begin
                mul_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.integ_gain};
                mul_b = {{(MUL_W-SUM_W){1'b0}}, isum_reg};
            end
            dpsv_pkg::MUL_SLO:
            begin
                mul_a = {{(MUL_W-SCALE_W){1'b0}}, sel_scale};
                mul_b = {{(MUL_W-SPLIT_W){1'b0}}, acc_reg[SPLIT_W-1:0]};
            end
            dpsv_pkg::MUL_SHI:
            begin
                mul_a = {{(MUL_W-SCALE_W){1'b0}}, sel_scale};
                mul_b = {{(MUL_W-HI_W){acc_reg[SPLIT_W+HI_W-1]}},
                         acc_reg[SPLIT_W+HI_W-1:SPLIT_W]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (ctrl.acc)
            dpsv_pkg::ACC_HOLD:   acc_next = acc_reg;
            dpsv_pkg::ACC_LOAD:   acc_next = prod_ext;
            dpsv_pkg::ACC_ADD:    acc_next = acc_reg + prod_ext;
            dpsv_pkg::ACC_ADD_HI: acc_next = acc_reg + (prod_ext <<< SPLIT_W);
            default:              acc_next = acc_reg;
        endcase
    end

    // The arithmetic shift floors toward minus infinity, as the drive needs.
    assign q_c       = acc_reg[ACC_W-1:SHIFT];
    assign drive_sum = $signed({q_c[Q_W-1], q_c})
                     + $signed({{(Q_W+1-LEVEL_W){1'b0}}, cfg.neutral_level});

    always_comb
    begin
        if (drive_sum[Q_W])
        begin
            drive_c = '0;
        end
        else if (drive_sum[Q_W-1:0] > {{(Q_W-LEVEL_W){1'b0}}, cfg.output_ceiling})
        begin
            drive_c = cfg.output_ceiling;
        end
        else
        begin
            drive_c = drive_sum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.in_load)
        begin
            x_smp_reg <= in_data.x_sample;
            y_smp_reg <= in_data.y_sample;
            touch_reg <= dpsv_pkg::touched(in_data);
        end
        if (ctrl.op == dpsv_pkg::DP_LOAD_ERR)
        begin
            err_reg  <= err_c;
            diff_reg <= diff_c;
            isum_reg <= sum_c;
        end
        if (ctrl.op == dpsv_pkg::DP_DRIVE)
        begin
            if (ctrl.axis == dpsv_pkg::AXIS_X)
            begin
                drive_x_reg <= drive_c;
            end
            else
            begin
                drive_y_reg <= drive_c;
            end
        end
        if (ctrl.op == dpsv_pkg::DP_NEUTRAL)
        begin
            drive_x_reg <= cfg.neutral_level;
            drive_y_reg <= cfg.neutral_level;
        end
        if (ctrl.out_load)
        begin
            out_reg.drive_x       <= drive_x_reg;
            out_reg.drive_y       <= drive_y_reg;
            out_reg.touch_present <= touch_reg;
        end
    end

    // Controller state: previous error and clamped integral per axis.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else if (ctrl.op == dpsv_pkg::DP_LOAD_ERR)
        begin
            if (ctrl.axis == dpsv_pkg::AXIS_X)
            begin
                last_x_reg <= err_c;
                sum_x_reg  <= sum_c;
            end
            else
            begin
                last_y_reg <= err_c;
                sum_y_reg  <= sum_c;
            end
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### rtl/core/dual_axis_pid_servo_unit.sv
// Top level of the two axis PID servo controller.
//
//  Port group | Handshake              | Payload
//  in         | in_valid / in_stall    | dpsv_pkg::in_t  (x_sample, y_sample)
//  out        | out_valid / out_stall  | dpsv_pkg::out_t (drive_x, drive_y, touch_present)
//  cfg        | cfg_wr_en              | cfg_index, cfg_data
//
// A touched item runs the PID steps of both axes before its result is loaded at the
// emit step; an untouched item runs only the neutral step. Nine program steps per
// axis push five products through one shared 21x21 multiplier and its accumulator.
// The input reopens the cycle after the result is loaded, so no new item is taken
// while one is in work; a stalled earlier result holds the sequencer at its emit
// step. Reset clears the step counter, the controller state and the output valid flag.
`default_nettype none

`include "dual_axis_pid_servo_unit_macros.svh"

module dual_axis_pid_servo_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  dpsv_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output dpsv_pkg::out_t                      out_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dpsv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dpsv_pkg::CFG_W-1:0]     cfg_data
);

    dpsv_pkg::cfg_t  cfg;
    dpsv_pkg::ctrl_t ctrl;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_busy;
    logic            in_touch;

    assign in_touch = dpsv_pkg::touched(in_data);
    assign out_busy = out_valid_reg && out_stall;

    dpsv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpsv_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_touch (in_touch),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    dpsv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_data  (in_data),
        .cfg      (cfg),
        .out_data (out_data)
    );

    always_comb
    begin
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A stalled result is never overwritten by the next one.
    `DPSV_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_busy, !ctrl.out_load)
    // Taking an item and emitting a result are different program steps.
    `DPSV_ASSERT_IMP(a_load_exclusive, clk, rst_n, ctrl.in_load, !ctrl.out_load)
    // Once an item is taken the input side closes until its work is done.
    `DPSV_ASSERT_NEXT(a_busy_after_load, clk, rst_n, ctrl.in_load, in_stall)
    // A loaded result is shown in the following cycle.
    `DPSV_ASSERT_NEXT(a_emit_shows, clk, rst_n, ctrl.out_load, out_valid)

endmodule

`default_nettype wire

### sim/tb_dual_axis_pid_servo_unit.sv
// Self-checking testbench for the two axis PID servo unit with a built-in predictor.
`default_nettype none

module tb_dual_axis_pid_servo_unit;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_COUNT    = 10;
    localparam int TICKS_PER_PHASE = 65;
    localparam int MAX_REPORTS    = 10;
    localparam logic [dpsv_pkg::CFG_IDX_W-1:0] REG_INDEX_UNMAPPED = 3'd7;

    typedef enum {TRACE_UNIFORM, TRACE_WALK, TRACE_LOW, TRACE_HIGH} trace_t;
    typedef enum {SET_DEFAULT, SET_TYPICAL, SET_WILD, SET_EXTREME} setting_t;

    typedef struct {
        dpsv_pkg::in_t  tick;
        dpsv_pkg::out_t want;
    } servo_expect_t;

    typedef struct {
        bit                             is_cfg;
        logic [dpsv_pkg::CFG_IDX_W-1:0] idx;
        logic [dpsv_pkg::CFG_W-1:0]     val;
        dpsv_pkg::in_t                  tick;
        bit                             known;
        dpsv_pkg::out_t                 want;
    } plan_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    dpsv_pkg::in_t                  in_data;
    logic                           out_valid;
    logic                           out_stall;
    dpsv_pkg::out_t                 out_data;
    logic                           cfg_wr_en;
    logic [dpsv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dpsv_pkg::CFG_W-1:0]     cfg_data;

    dpsv_pkg::cfg_t servo_cfg;
    int             prev_err [2];
    int             err_acc [2];
    servo_expect_t  servo_expected [$];
    int             mismatch_count;
    int             cycle_count;
    bit             steady_flow;
    int             walk_x;
    int             walk_y;

    dual_axis_pid_servo_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One PID step of one axis; updates that axis's error history and integral.
    function automatic logic [dpsv_pkg::LEVEL_W-1:0] servo_axis(
        input dpsv_pkg::axis_t               axis,
        input logic [dpsv_pkg::SAMPLE_W-1:0] target,
        input logic [dpsv_pkg::SAMPLE_W-1:0] smp,
        input longint                        scale);
        int     e;
        int     d;
        int     s;
        longint tau;
        longint drv;
        e = int'(target) - int'(smp);
        d = e - prev_err[axis];
        s = err_acc[axis] + e;
        if (s < int'(dpsv_pkg::SUM_LOW))
            s = int'(dpsv_pkg::SUM_LOW);
        else if (s > int'(dpsv_pkg::SUM_HIGH))
            s = int'(dpsv_pkg::SUM_HIGH);
        tau = longint'(servo_cfg.prop_gain) * e + longint'(servo_cfg.deriv_gain) * d
            + longint'(servo_cfg.integ_gain) * s;
        // Arithmetic shift of a signed value rounds toward minus infinity.
        drv = ((tau * scale) >>> dpsv_pkg::DRIVE_SHIFT)
            + longint'(servo_cfg.neutral_level);
        if (drv < 0)
            drv = 0;
        if (drv > longint'(servo_cfg.output_ceiling))
            drv = longint'(servo_cfg.output_ceiling);
        prev_err[axis] = e;
        err_acc[axis]  = s;
        return drv[dpsv_pkg::LEVEL_W-1:0];
    endfunction

    function automatic dpsv_pkg::out_t servo_step(input dpsv_pkg::in_t tick);
        dpsv_pkg::out_t r;
        if (tick.x_sample != '0 && tick.y_sample != '1)
        begin
            r.drive_x = servo_axis(dpsv_pkg::AXIS_X, servo_cfg.setpoint_x, tick.x_sample,
                                   longint'(dpsv_pkg::SCALE_X));
            r.drive_y = servo_axis(dpsv_pkg::AXIS_Y, servo_cfg.setpoint_y, tick.y_sample,
                                   longint'(dpsv_pkg::SCALE_Y));
            r.touch_present = 1'b1;
        end
        else
        begin
            r.drive_x       = servo_cfg.neutral_level;
            r.drive_y       = servo_cfg.neutral_level;
            r.touch_present = 1'b0;
        end
        return r;
    endfunction

    function automatic dpsv_pkg::in_t next_tick(input trace_t mode);
        dpsv_pkg::in_t t;
        case (mode)
            TRACE_UNIFORM:
            begin
                t.x_sample = dpsv_pkg::SAMPLE_W'($urandom_range(0, 4095));
                t.y_sample = dpsv_pkg::SAMPLE_W'($urandom_range(0, 4095));
            end
            TRACE_WALK:
            begin
                walk_x = walk_x + $urandom_range(0, 64) - 32;
                walk_y = walk_y + $urandom_range(0, 64) - 32;
                walk_x = (walk_x < 1) ? 1 : (walk_x > 4094) ? 4094 : walk_x;
                walk_y = (walk_y < 1) ? 1 : (walk_y > 4094) ? 4094 : walk_y;
                t.x_sample = dpsv_pkg::SAMPLE_W'(walk_x);
                t.y_sample = dpsv_pkg::SAMPLE_W'(walk_y);
            end
            TRACE_LOW:
            begin
                t.x_sample = dpsv_pkg::SAMPLE_W'($urandom_range(1, 300));
                t.y_sample = dpsv_pkg::SAMPLE_W'($urandom_range(0, 300));
            end
            default:
            begin
                t.x_sample = dpsv_pkg::SAMPLE_W'($urandom_range(3800, 4095));
                t.y_sample = dpsv_pkg::SAMPLE_W'($urandom_range(3800, 4094));
            end
        endcase
        // A lifted finger now and then.
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
                t.x_sample = '0;
            else
                t.y_sample = '1;
        end
        return t;
    endfunction

    function automatic plan_row_t tick_row(input logic [dpsv_pkg::SAMPLE_W-1:0] x,
                                           input logic [dpsv_pkg::SAMPLE_W-1:0] y);
        plan_row_t r;
        r.is_cfg        = 1'b0;
        r.idx           = '0;
        r.val           = '0;
        r.tick.x_sample = x;
        r.tick.y_sample = y;
        r.known         = 1'b0;
        r.want          = '0;
        return r;
    endfunction

    function automatic plan_row_t known_row(input logic [dpsv_pkg::SAMPLE_W-1:0] x,
                                            input logic [dpsv_pkg::SAMPLE_W-1:0] y,
                                            input logic [dpsv_pkg::LEVEL_W-1:0] dx,
                                            input logic [dpsv_pkg::LEVEL_W-1:0] dy,
                                            input logic tp);
        plan_row_t r;
        r                    = tick_row(x, y);
        r.known              = 1'b1;
        r.want.drive_x       = dx;
        r.want.drive_y       = dy;
        r.want.touch_present = tp;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [dpsv_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [dpsv_pkg::CFG_W-1:0] val);
        plan_row_t r;
        r        = tick_row('0, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    // Presents one item, after a random gap unless the flow is steady; returns at the edge that takes it.
    task automatic send_tick(input dpsv_pkg::in_t tick, input bit typed,
                             input dpsv_pkg::out_t typed_want);
        int            gap;
        servo_expect_t e;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        e.tick = tick;
        e.want = servo_step(tick);
        if (typed)
            e.want = typed_want;
        servo_expected.push_back(e);
    endtask

    // Leaves the block idle with every pending result delivered.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (servo_expected.size() != 0)
            @(posedge clk);
    endtask

    // The write enable stays high between back-to-back writes; callers lower it.
    task automatic write_reg(input logic [dpsv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpsv_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (dpsv_pkg::cfg_reg_t'(idx))
            dpsv_pkg::REG_SETPOINT_X:
                servo_cfg.setpoint_x     = val[dpsv_pkg::SAMPLE_W-1:0];
            dpsv_pkg::REG_SETPOINT_Y:
                servo_cfg.setpoint_y     = val[dpsv_pkg::SAMPLE_W-1:0];
            dpsv_pkg::REG_PROP_GAIN:
                servo_cfg.prop_gain      = val[dpsv_pkg::GAIN_W-1:0];
            dpsv_pkg::REG_DERIV_GAIN:
                servo_cfg.deriv_gain     = val[dpsv_pkg::GAIN_W-1:0];
            dpsv_pkg::REG_INTEG_GAIN:
                servo_cfg.integ_gain     = val[dpsv_pkg::GAIN_W-1:0];
            dpsv_pkg::REG_NEUTRAL_LEVEL:
                servo_cfg.neutral_level  = val[dpsv_pkg::LEVEL_W-1:0];
            dpsv_pkg::REG_OUTPUT_CEILING:
                servo_cfg.output_ceiling = val[dpsv_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin : receiver
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = steady_flow ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin : result_check
        servo_expect_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            if (servo_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: drive_x=%0d drive_y=%0d touch=%0b",
                             out_data.drive_x, out_data.drive_y, out_data.touch_present);
            end
            else
            begin
                head = servo_expected.pop_front();
                if (out_data.drive_x !== head.want.drive_x
                    || out_data.drive_y !== head.want.drive_y
                    || out_data.touch_present !== head.want.touch_present)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch x=%0d y=%0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 head.tick.x_sample, head.tick.y_sample,
                                 head.want.drive_x, head.want.drive_y,
                                 head.want.touch_present, out_data.drive_x,
                                 out_data.drive_y, out_data.touch_present);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_row_t                  plan [$];
        logic [dpsv_pkg::CFG_W-1:0] vals [8];
        bit                         writing;
        setting_t                   kind;
        trace_t                     mode;
        int                         sent;
        int                         len;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady_flow    = 1'b0;
        writing        = 1'b0;
        walk_x         = 2047;
        walk_y         = 2047;
        prev_err       = '{0, 0};
        err_acc        = '{0, 0};
        servo_cfg.setpoint_x     = dpsv_pkg::SETPOINT_RST;
        servo_cfg.setpoint_y     = dpsv_pkg::SETPOINT_RST;
        servo_cfg.prop_gain      = dpsv_pkg::PROP_RST;
        servo_cfg.deriv_gain     = dpsv_pkg::DERIV_RST;
        servo_cfg.integ_gain     = dpsv_pkg::INTEG_RST;
        servo_cfg.neutral_level  = dpsv_pkg::NEUTRAL_RST;
        servo_cfg.output_ceiling = dpsv_pkg::CEILING_RST;

        // Untouched panel in each of its forms, then PID steps at the sample extremes.
        plan.push_back(known_row(12'd0, 12'd100, 16'd1875, 16'd1875, 1'b0));
        plan.push_back(known_row(12'd5, 12'hFFF, 16'd1875, 16'd1875, 1'b0));
        plan.push_back(known_row(12'd0, 12'hFFF, 16'd1875, 16'd1875, 1'b0));
        plan.push_back(tick_row(12'd2047, 12'd2047));
        plan.push_back(tick_row(12'd1, 12'd0));
        plan.push_back(tick_row(12'd4095, 12'd4094));
        plan.push_back(tick_row(12'd4095, 12'd0));
        plan.push_back(tick_row(12'd1, 12'd4094));
        plan.push_back(tick_row(12'hAAA, 12'h555));
        plan.push_back(reg_row(REG_INDEX_UNMAPPED, 20'hFFFFF));
        plan.push_back(known_row(12'd0, 12'd0, 16'd1875, 16'd1875, 1'b0));
        plan.push_back(reg_row(dpsv_pkg::REG_NEUTRAL_LEVEL, 20'hA0123));
        plan.push_back(known_row(12'd0, 12'd7, 16'h0123, 16'h0123, 1'b0));
        plan.push_back(reg_row(dpsv_pkg::REG_OUTPUT_CEILING, 20'hF0000));
        plan.push_back(known_row(12'd100, 12'd200, 16'd0, 16'd0, 1'b1));
        plan.push_back(reg_row(dpsv_pkg::REG_PROP_GAIN, 20'd0));
        plan.push_back(reg_row(dpsv_pkg::REG_DERIV_GAIN, 20'd0));
        plan.push_back(reg_row(dpsv_pkg::REG_INTEG_GAIN, 20'd0));
        plan.push_back(reg_row(dpsv_pkg::REG_NEUTRAL_LEVEL, 20'h0FFFF));
        plan.push_back(reg_row(dpsv_pkg::REG_OUTPUT_CEILING, 20'd1000));
        // Neutral above the ceiling is clipped only when the PID runs.
        plan.push_back(known_row(12'd300, 12'd300, 16'd1000, 16'd1000, 1'b1));
        plan.push_back(known_row(12'd0, 12'd300, 16'hFFFF, 16'hFFFF, 1'b0));
        plan.push_back(reg_row(dpsv_pkg::REG_NEUTRAL_LEVEL, 20'd0));
        plan.push_back(reg_row(dpsv_pkg::REG_OUTPUT_CEILING, 20'hFFFFF));
        plan.push_back(known_row(12'd4095, 12'd1, 16'd0, 16'd0, 1'b1));
        plan.push_back(reg_row(dpsv_pkg::REG_PROP_GAIN, 20'hFFFFF));
        plan.push_back(reg_row(dpsv_pkg::REG_DERIV_GAIN, 20'hFFFFF));
        plan.push_back(reg_row(dpsv_pkg::REG_INTEG_GAIN, 20'hFFFFF));
        plan.push_back(reg_row(dpsv_pkg::REG_SETPOINT_X, 20'hFFFFF));
        plan.push_back(reg_row(dpsv_pkg::REG_SETPOINT_Y, 20'hFF000));
        plan.push_back(reg_row(dpsv_pkg::REG_NEUTRAL_LEVEL, 20'd32768));
        plan.push_back(tick_row(12'd1, 12'd4094));
        plan.push_back(tick_row(12'd4095, 12'd1));
        plan.push_back(tick_row(12'd2048, 12'd2048));
        plan.push_back(tick_row(12'd1, 12'd1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (!writing)
                begin
                    quiesce();
                    writing = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                if (writing)
                begin
                    cfg_wr_en <= 1'b0;
                    writing = 1'b0;
                end
                send_tick(plan[i].tick, plan[i].known, plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            quiesce();
            if (phase == 0)
                kind = SET_DEFAULT;
            else if (phase == PHASE_COUNT - 1)
                kind = SET_EXTREME;
            else
                kind = setting_t'($urandom_range(1, 3));
            case (kind)
                SET_DEFAULT:
                begin
                    vals[dpsv_pkg::REG_SETPOINT_X]     =
                        dpsv_pkg::CFG_W'(dpsv_pkg::SETPOINT_RST);
                    vals[dpsv_pkg::REG_SETPOINT_Y]     =
                        dpsv_pkg::CFG_W'(dpsv_pkg::SETPOINT_RST);
                    vals[dpsv_pkg::REG_PROP_GAIN]      = dpsv_pkg::PROP_RST;
                    vals[dpsv_pkg::REG_DERIV_GAIN]     = dpsv_pkg::DERIV_RST;
                    vals[dpsv_pkg::REG_INTEG_GAIN]     = dpsv_pkg::INTEG_RST;
                    vals[dpsv_pkg::REG_NEUTRAL_LEVEL]  =
                        dpsv_pkg::CFG_W'(dpsv_pkg::NEUTRAL_RST);
                    vals[dpsv_pkg::REG_OUTPUT_CEILING] =
                        dpsv_pkg::CFG_W'(dpsv_pkg::CEILING_RST);
                end
                SET_TYPICAL:
                begin
                    vals[dpsv_pkg::REG_SETPOINT_X]     =
                        dpsv_pkg::CFG_W'($urandom_range(0, 4095));
                    vals[dpsv_pkg::REG_SETPOINT_Y]     =
                        dpsv_pkg::CFG_W'($urandom_range(0, 4095));
                    vals[dpsv_pkg::REG_PROP_GAIN]      =
                        dpsv_pkg::CFG_W'($urandom_range(0, 40000));
                    vals[dpsv_pkg::REG_DERIV_GAIN]     =
                        dpsv_pkg::CFG_W'($urandom_range(0, 400000));
                    vals[dpsv_pkg::REG_INTEG_GAIN]     =
                        dpsv_pkg::CFG_W'($urandom_range(0, 1000));
                    vals[dpsv_pkg::REG_NEUTRAL_LEVEL]  =
                        dpsv_pkg::CFG_W'($urandom_range(500, 3000));
                    vals[dpsv_pkg::REG_OUTPUT_CEILING] =
                        vals[dpsv_pkg::REG_NEUTRAL_LEVEL]
                        + dpsv_pkg::CFG_W'($urandom_range(0, 3000));
                end
                SET_WILD:
                begin
                    // Full width values also exercise masking of the unused bits.
                    for (int r = 0; r < 7; r++)
                        vals[r] = dpsv_pkg::CFG_W'($urandom());
                end
                default:
                begin
                    for (int r = 0; r < 7; r++)
                        vals[r] = ($urandom_range(0, 1) == 1) ? '1 : '0;
                end
            endcase
            vals[REG_INDEX_UNMAPPED] = dpsv_pkg::CFG_W'($urandom());
            for (int r = 0; r < 8; r++)
                write_reg(dpsv_pkg::CFG_IDX_W'(r), vals[r]);
            cfg_wr_en <= 1'b0;

            walk_x = int'(servo_cfg.setpoint_x);
            walk_y = int'(servo_cfg.setpoint_y);
            sent = 0;
            while (sent < TICKS_PER_PHASE)
            begin
                mode        = trace_t'($urandom_range(0, 3));
                steady_flow = ($urandom_range(0, 3) == 0);
                len         = $urandom_range(8, 30);
                if (len > TICKS_PER_PHASE - sent)
                    len = TICKS_PER_PHASE - sent;
                repeat (len)
                begin
                    send_tick(next_tick(mode), 1'b0, '0);
                    sent++;
                end
            end
        end

        steady_flow = 1'b0;
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && servo_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
